@@ hw/rtl/mmwp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max wave plotter package
// Shared widths, register index codes and the control struct that travels
// between the bucket tracker and the span mapper.
// ----------------------------------------------------------------------------
package mmwp_pkg;

  // Default values for the top-level parameters.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COORD_BITS_DEF  = 12;

  // Fixed widths of the configuration registers and the frame state.
  localparam int COUNT_BITS    = 16;
  localparam int INDEX_BITS    = 32;
  localparam int SCALE_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int DIM_BITS      = 13;
  localparam int X_ORIGIN_BITS = 32;
  localparam int Y_ORIGIN_BITS = 16;

  // Configuration port widths.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Rows added above and below a span.
  localparam int ROW_MARGIN = 2;

  // Reset values of the configuration registers.
  localparam logic [COUNT_BITS-1:0]    BUCKET_LEN_RST = 16'd1;
  localparam logic [SCALE_BITS-1:0]    COL_SCALE_RST  = 32'd65536;
  localparam logic [X_ORIGIN_BITS-1:0] X_ORIGIN_RST   = 32'd0;
  localparam logic [SCALE_BITS-1:0]    ROW_SCALE_RST  = 32'd65536;
  localparam logic [Y_ORIGIN_BITS-1:0] Y_ORIGIN_RST   = 16'd0;
  localparam logic [DIM_BITS-1:0]      IMG_WIDTH_RST  = 13'd256;
  localparam logic [DIM_BITS-1:0]      IMG_HEIGHT_RST = 13'd256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BUCKET_LEN = 3'd0,
    REG_COL_SCALE  = 3'd1,
    REG_X_ORIGIN   = 3'd2,
    REG_ROW_SCALE  = 3'd3,
    REG_Y_ORIGIN   = 3'd4,
    REG_IMG_WIDTH  = 3'd5,
    REG_IMG_HEIGHT = 3'd6
  } cfg_reg_t;

  // Control of one closed bucket: valid and the signs of the three offsets
  // whose magnitudes travel beside it.
  typedef struct packed {
    logic valid;
    logic col_neg;
    logic min_neg;
    logic max_neg;
  } mmwp_span_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/mmwp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max wave plotter channels
// Valid/ready channels for samples, spans and configuration writes.
// ----------------------------------------------------------------------------
interface mmwp_in_if import mmwp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mmwp_out_if import mmwp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row_low;
  logic [COORD_BITS-1:0] row_high;

  modport source (output valid, output column, output row_low, output row_high,
                  input ready);
  modport sink   (input valid, input column, input row_low, input row_high,
                  output ready);
endinterface

interface mmwp_cfg_if import mmwp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mmwp_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max wave plotter bucket tracker
// Folds samples into the running min/max, counts the bucket and registers
// the offsets of every closed bucket for the span mapper.
// ----------------------------------------------------------------------------
module mmwp_tracker import mmwp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mmwp_in_if.sink                              in_chan,
  input  wire logic        [COUNT_BITS-1:0]    bucket_len,
  input  wire logic signed [X_ORIGIN_BITS-1:0] x_origin,
  input  wire logic signed [Y_ORIGIN_BITS-1:0] y_origin,
  output mmwp_span_ctl_t                       span_ctl,
  output logic [INDEX_BITS:0]                  span_col_mag,
  output logic [((SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS : Y_ORIGIN_BITS)-1:0]
                                               span_min_mag,
  output logic [((SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS : Y_ORIGIN_BITS)-1:0]
                                               span_max_mag,
  input  wire logic                            span_ready
);

  localparam int DIFF_BITS     = ((SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS
                                                                : Y_ORIGIN_BITS) + 1;
  localparam int COL_DIFF_BITS = INDEX_BITS + 2;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0]         COUNT_SAT    = {COUNT_BITS{1'b1}};

  logic [INDEX_BITS-1:0]         sample_index_r, sample_index_nxt;
  logic [COUNT_BITS-1:0]         bucket_count_r, bucket_count_nxt, count_base;
  logic signed [SAMPLE_BITS-1:0] run_min_r, run_min_nxt, fold_min;
  logic signed [SAMPLE_BITS-1:0] run_max_r, run_max_nxt, fold_max;
  logic                          in_xfer, close_bucket;

  logic signed [COL_DIFF_BITS-1:0] col_diff, col_ndiff, x_ext;
  logic signed [DIFF_BITS-1:0]     min_diff, min_ndiff, max_diff, max_ndiff, y_ext;

  mmwp_span_ctl_t             span_ctl_r;
  logic [INDEX_BITS:0]        col_mag_r;
  logic [DIFF_BITS-2:0]       min_mag_r, max_mag_r;

  assign in_chan.ready = !span_ctl_r.valid || span_ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // The new sample joins the running extremes before the bucket is checked.
  assign fold_min     = (in_chan.sample < run_min_r) ? in_chan.sample : run_min_r;
  assign fold_max     = (in_chan.sample > run_max_r) ? in_chan.sample : run_max_r;
  assign close_bucket = (bucket_count_r >= bucket_len);

  always_comb begin
    count_base = close_bucket ? '0 : bucket_count_r;
    if (in_chan.last_sample) begin
      sample_index_nxt = '0;
      bucket_count_nxt = '0;
      run_min_nxt      = SMP_MOST_POS;
      run_max_nxt      = SMP_MOST_NEG;
    end else begin
      sample_index_nxt = sample_index_r + INDEX_BITS'(1);
      bucket_count_nxt = (count_base == COUNT_SAT) ? count_base
                                                   : count_base + COUNT_BITS'(1);
      run_min_nxt      = close_bucket ? SMP_MOST_POS : fold_min;
      run_max_nxt      = close_bucket ? SMP_MOST_NEG : fold_max;
    end
  end

  // Both signs of each offset are formed side by side so the magnitude is a
  // single subtract followed by a select.
  assign x_ext     = {{(COL_DIFF_BITS-X_ORIGIN_BITS){x_origin[X_ORIGIN_BITS-1]}}, x_origin};
  assign col_diff  = $signed({2'b00, sample_index_r}) - x_ext;
  assign col_ndiff = x_ext - $signed({2'b00, sample_index_r});

  assign y_ext     = {{(DIFF_BITS-Y_ORIGIN_BITS){y_origin[Y_ORIGIN_BITS-1]}}, y_origin};
  assign min_diff  = {{(DIFF_BITS-SAMPLE_BITS){fold_min[SAMPLE_BITS-1]}}, fold_min} - y_ext;
  assign min_ndiff = y_ext - {{(DIFF_BITS-SAMPLE_BITS){fold_min[SAMPLE_BITS-1]}}, fold_min};
  assign max_diff  = {{(DIFF_BITS-SAMPLE_BITS){fold_max[SAMPLE_BITS-1]}}, fold_max} - y_ext;
  assign max_ndiff = y_ext - {{(DIFF_BITS-SAMPLE_BITS){fold_max[SAMPLE_BITS-1]}}, fold_max};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r   <= '0;
      bucket_count_r   <= '0;
      run_min_r        <= SMP_MOST_POS;
      run_max_r        <= SMP_MOST_NEG;
      span_ctl_r       <= '0;
    end else begin
      if (in_xfer) begin
        sample_index_r <= sample_index_nxt;
        bucket_count_r <= bucket_count_nxt;
        run_min_r      <= run_min_nxt;
        run_max_r      <= run_max_nxt;
      end
      if (in_chan.ready) begin
        span_ctl_r.valid   <= in_xfer && close_bucket;
        span_ctl_r.col_neg <= col_diff[COL_DIFF_BITS-1];
        span_ctl_r.min_neg <= min_diff[DIFF_BITS-1];
        span_ctl_r.max_neg <= max_diff[DIFF_BITS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && close_bucket) begin
      col_mag_r <= col_diff[COL_DIFF_BITS-1] ? col_ndiff[COL_DIFF_BITS-2:0]
                                             : col_diff[COL_DIFF_BITS-2:0];
      min_mag_r <= min_diff[DIFF_BITS-1] ? min_ndiff[DIFF_BITS-2:0] : min_diff[DIFF_BITS-2:0];
      max_mag_r <= max_diff[DIFF_BITS-1] ? max_ndiff[DIFF_BITS-2:0] : max_diff[DIFF_BITS-2:0];
    end
  end

  assign span_ctl     = span_ctl_r;
  assign span_col_mag = col_mag_r;
  assign span_min_mag = min_mag_r;
  assign span_max_mag = max_mag_r;

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_chan.last_sample |=> sample_index_r == '0 && bucket_count_r == '0)
    else $error("frame state not cleared after last sample");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_chan.last_sample |=> bucket_count_r != '0)
    else $error("bucket counter zero after a plain sample");

  a_extremes_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_chan.last_sample && !close_bucket |=> run_min_r <= run_max_r)
    else $error("running minimum above running maximum");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/mmwp_mapper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max wave plotter span mapper
// Scales the offsets of a closed bucket to a column and a clamped row span,
// with a multiply stage, a finishing stage and the output register.
// ----------------------------------------------------------------------------
module mmwp_mapper import mmwp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mmwp_span_ctl_t        span_ctl,
  input  wire logic [INDEX_BITS:0]   span_col_mag,
  input  wire logic [((SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS : Y_ORIGIN_BITS)-1:0]
                                     span_min_mag,
  input  wire logic [((SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS : Y_ORIGIN_BITS)-1:0]
                                     span_max_mag,
  output logic                       span_ready,
  input  wire logic [SCALE_BITS-1:0] col_scale,
  input  wire logic [SCALE_BITS-1:0] row_scale,
  input  wire logic [DIM_BITS-1:0]   img_width,
  input  wire logic [DIM_BITS-1:0]   img_height,
  mmwp_out_if.source                 out_chan
);

  localparam int ROW_MAG_BITS  = (SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS : Y_ORIGIN_BITS;
  localparam int COL_MAG_BITS  = INDEX_BITS + 1;
  localparam int COL_LO_BITS   = FRAC_BITS + SCALE_BITS;
  localparam int COL_HI_BITS   = COL_MAG_BITS - FRAC_BITS + SCALE_BITS;
  localparam int COL_Q_BITS    = COL_HI_BITS + 1;
  localparam int ROW_PROD_BITS = ROW_MAG_BITS + SCALE_BITS;
  localparam int ROW_R_BITS    = ROW_PROD_BITS - FRAC_BITS + 2;
  localparam int LIM_BITS      = (COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS;
  localparam logic [LIM_BITS-1:0] COORD_LIMIT = LIM_BITS'(1) << COORD_BITS;

  // Multiply stage.
  logic                     mul_valid_r;
  logic                     col_neg_r, min_neg_r, max_neg_r;
  logic [COL_LO_BITS-1:0]   col_lo_r;
  logic [COL_HI_BITS-1:0]   col_hi_r;
  logic [ROW_PROD_BITS-1:0] min_prod_r, max_prod_r;

  // Finishing stage and output register.
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] column_r, row_low_r, row_high_r;
  logic [COORD_BITS-1:0] column_nxt, row_low_nxt, row_high_nxt;
  logic                  mul_ready, out_load;
  logic [COL_Q_BITS-1:0] col_q;
  logic [LIM_BITS-1:0]   width_eff, height_eff, row_limit;
  logic                  col_ok;

  assign out_load   = !out_valid_r || out_chan.ready;
  assign mul_ready  = !mul_valid_r || out_load;
  assign span_ready = mul_ready;

  // floor(d * scale / 2^16 + k) for a signed offset d, clamped to 0..lim.
  function automatic logic [COORD_BITS-1:0] row_map(
    input logic [ROW_PROD_BITS-1:0] prod,
    input logic                     neg,
    input logic                     widen_up,
    input logic [LIM_BITS-1:0]      lim
  );
    logic signed [ROW_R_BITS-1:0] q;
    logic signed [ROW_R_BITS-1:0] k;
    logic signed [ROW_R_BITS-1:0] r;
    logic signed [ROW_R_BITS-1:0] frac;
    q    = $signed({2'b00, prod[ROW_PROD_BITS-1:FRAC_BITS]});
    frac = $signed({{(ROW_R_BITS-1){1'b0}}, |prod[FRAC_BITS-1:0]});
    k    = widen_up ? ROW_R_BITS'(ROW_MARGIN) : -ROW_R_BITS'(ROW_MARGIN);
    r    = neg ? (k - q - frac) : (q + k);
    if (r < 0) begin
      row_map = '0;
    end else if (r > $signed(ROW_R_BITS'(lim))) begin
      row_map = lim[COORD_BITS-1:0];
    end else begin
      row_map = r[COORD_BITS-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_r <= span_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && span_ctl.valid) begin
      col_neg_r  <= span_ctl.col_neg;
      min_neg_r  <= span_ctl.min_neg;
      max_neg_r  <= span_ctl.max_neg;
      col_lo_r   <= COL_LO_BITS'(span_col_mag[FRAC_BITS-1:0]) * COL_LO_BITS'(col_scale);
      col_hi_r   <= COL_HI_BITS'(span_col_mag[COL_MAG_BITS-1:FRAC_BITS])
                    * COL_HI_BITS'(col_scale);
      min_prod_r <= ROW_PROD_BITS'(span_min_mag) * ROW_PROD_BITS'(row_scale);
      max_prod_r <= ROW_PROD_BITS'(span_max_mag) * ROW_PROD_BITS'(row_scale);
    end
  end

  always_comb begin
    width_eff  = (LIM_BITS'(img_width) > COORD_LIMIT) ? COORD_LIMIT : LIM_BITS'(img_width);
    height_eff = (LIM_BITS'(img_height) > COORD_LIMIT) ? COORD_LIMIT : LIM_BITS'(img_height);
    if (height_eff == '0) begin
      height_eff = LIM_BITS'(1);
    end
    row_limit = height_eff - LIM_BITS'(1);

    col_q = COL_Q_BITS'(col_hi_r) + COL_Q_BITS'(col_lo_r[COL_LO_BITS-1:FRAC_BITS]);
    if (col_neg_r) begin
      // A negative offset lands on column zero only if it rounds to zero.
      col_ok     = (col_q == '0) && (width_eff != '0);
      column_nxt = '0;
    end else begin
      col_ok     = col_q < COL_Q_BITS'(width_eff);
      column_nxt = col_q[COORD_BITS-1:0];
    end
    row_low_nxt  = row_map(min_prod_r, min_neg_r, 1'b0, row_limit);
    row_high_nxt = row_map(max_prod_r, max_neg_r, 1'b1, row_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= mul_valid_r && col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && mul_valid_r) begin
      column_r   <= column_nxt;
      row_low_r  <= row_low_nxt;
      row_high_r <= row_high_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.column   = column_r;
  assign out_chan.row_low  = row_low_r;
  assign out_chan.row_high = row_high_r;

`ifndef SYNTHESIS
  a_span_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> row_low_r <= row_high_r)
    else $error("span lower row above upper row");

  a_column_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> LIM_BITS'(column_r) < width_eff)
    else $error("span column outside the image");

  a_span_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(column_r)
      && $stable(row_low_r) && $stable(row_high_r))
    else $error("span changed while the receiver stalled");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/minmax_decimating_wave_plotter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min/max decimating wave plotter
// Peak-detect decimation of a sample stream into vertical column spans.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one signed sample per transfer, with last_sample marking
//   the final sample of a frame. out_chan carries one span (column, row_low,
//   row_high) for every bucket that closes on a column inside the image;
//   buckets that fall outside produce nothing. cfg_chan writes one register
//   per transfer and is always ready; the user must write it only while no
//   sample is in flight, as the block itself does not enforce this.
//   Throughput is one sample per cycle while out_chan accepts spans. A span
//   passes from the sample that closes its bucket through the tracker's
//   bucket register, the multiply stage and the rounding and clamping stage
//   that loads the output register.
//   When out_chan stalls, the output register holds the span while the two
//   internal stages keep filling; in_chan drops ready only once the multiply
//   stage and the tracker's bucket register are both occupied.
//   Synchronous reset restores the register defaults and clears the sample
//   index, bucket counter and running min/max; a sample with last_sample set
//   clears the same frame state after it is processed, keeping registers.
// ----------------------------------------------------------------------------
module minmax_decimating_wave_plotter_unit import mmwp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mmwp_in_if.sink    in_chan,
  mmwp_out_if.source out_chan,
  mmwp_cfg_if.sink   cfg_chan
);

  localparam int ROW_MAG_BITS = (SAMPLE_BITS > Y_ORIGIN_BITS) ? SAMPLE_BITS : Y_ORIGIN_BITS;

  // Configuration registers.
  logic [COUNT_BITS-1:0]           bucket_len_r;
  logic [SCALE_BITS-1:0]           col_scale_r;
  logic signed [X_ORIGIN_BITS-1:0] x_origin_r;
  logic [SCALE_BITS-1:0]           row_scale_r;
  logic signed [Y_ORIGIN_BITS-1:0] y_origin_r;
  logic [DIM_BITS-1:0]             img_width_r;
  logic [DIM_BITS-1:0]             img_height_r;

  // Closed-bucket hand-off from tracker to mapper.
  mmwp_span_ctl_t          span_ctl;
  logic [INDEX_BITS:0]     span_col_mag;
  logic [ROW_MAG_BITS-1:0] span_min_mag, span_max_mag;
  logic                    span_ready;

  // Writes take effect in the next cycle, so the port never needs to stall.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_len_r <= BUCKET_LEN_RST;
      col_scale_r  <= COL_SCALE_RST;
      x_origin_r   <= X_ORIGIN_RST;
      row_scale_r  <= ROW_SCALE_RST;
      y_origin_r   <= Y_ORIGIN_RST;
      img_width_r  <= IMG_WIDTH_RST;
      img_height_r <= IMG_HEIGHT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_BUCKET_LEN: begin
          bucket_len_r <= cfg_chan.data[COUNT_BITS-1:0];
        end
        REG_COL_SCALE: begin
          col_scale_r <= cfg_chan.data[SCALE_BITS-1:0];
        end
        REG_X_ORIGIN: begin
          x_origin_r <= cfg_chan.data[X_ORIGIN_BITS-1:0];
        end
        REG_ROW_SCALE: begin
          row_scale_r <= cfg_chan.data[SCALE_BITS-1:0];
        end
        REG_Y_ORIGIN: begin
          y_origin_r <= cfg_chan.data[Y_ORIGIN_BITS-1:0];
        end
        REG_IMG_WIDTH: begin
          img_width_r <= cfg_chan.data[DIM_BITS-1:0];
        end
        REG_IMG_HEIGHT: begin
          img_height_r <= cfg_chan.data[DIM_BITS-1:0];
        end
        default: begin
          // Unused indexes are ignored.
        end
      endcase
    end
  end

  // The tracker owns the frame state and hands over the offsets of each
  // bucket as it closes.
  mmwp_tracker #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .bucket_len   (bucket_len_r),
    .x_origin     (x_origin_r),
    .y_origin     (y_origin_r),
    .span_ctl     (span_ctl),
    .span_col_mag (span_col_mag),
    .span_min_mag (span_min_mag),
    .span_max_mag (span_max_mag),
    .span_ready   (span_ready)
  );

  // The mapper scales the offsets, drops off-image columns and drives the
  // output register.
  mmwp_mapper #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_mapper (
    .clk          (clk),
    .rst_n        (rst_n),
    .span_ctl     (span_ctl),
    .span_col_mag (span_col_mag),
    .span_min_mag (span_min_mag),
    .span_max_mag (span_max_mag),
    .span_ready   (span_ready),
    .col_scale    (col_scale_r),
    .row_scale    (row_scale_r),
    .img_width    (img_width_r),
    .img_height   (img_height_r),
    .out_chan     (out_chan)
  );

endmodule
`default_nettype wire
